FILE: design/dbpm_pkg.sv
// Shared types and constants for the dot-bracket pair matcher.
package dbpm_pkg;

   localparam int SYM_W   = 8;
   localparam int FIELD_W = 10;
   localparam int POS_W   = 11;
   localparam int CODE_W  = 2;
   localparam int SEL_W   = 2;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int TIU_W   = 3;

   localparam logic [SYM_W-1:0]   DOT_CHAR      = 8'h2E;
   localparam logic [FIELD_W-1:0] POS_FIELD_MAX = 10'd1023;

   localparam logic [CSR_W-1:0] OPEN_SYMBOLS_RST  = 32'd1014717224;
   localparam logic [CSR_W-1:0] CLOSE_SYMBOLS_RST = 32'd1048403241;
   localparam logic [TIU_W-1:0] TYPES_IN_USE_RST  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_SYMBOLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_SYMBOLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPES_IN_USE  = 2'd2;

   localparam logic [CODE_W-1:0] KIND_UNPAIRED = 2'd0;
   localparam logic [CODE_W-1:0] KIND_PAIR     = 2'd1;
   localparam logic [CODE_W-1:0] KIND_SUMMARY  = 2'd2;

   localparam logic [CODE_W-1:0] ERR_OK            = 2'd0;
   localparam logic [CODE_W-1:0] ERR_CLOSE_NO_OPEN = 2'd1;
   localparam logic [CODE_W-1:0] ERR_OPENS_LEFT    = 2'd2;
   localparam logic [CODE_W-1:0] ERR_OVERFLOW      = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DOT,
      OP_OPEN,
      OP_CLOSE
   } op_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_symbol;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] partner;
      logic [CODE_W-1:0]  kind;
      logic [CODE_W-1:0]  error_code;
      logic [FIELD_W-1:0] pair_count;
      logic               run_end;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [SEL_W-1:0] sel;
   } dec_type;

   typedef struct packed {
      logic               exec;
      logic               clear;
      op_type             op;
      logic [SEL_W-1:0]   sel;
      logic [FIELD_W-1:0] position;
   } stk_cmd_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic               any_left;
      logic [FIELD_W-1:0] top;
   } stk_status_type;

endpackage

FILE: design/dbpm_decode.sv
// Symbol decoder: classifies one byte as dot, open or close of a bracket type.
module dbpm_decode #(
   parameter int NUM_TYPES = 4
) (
   input  logic [dbpm_pkg::SYM_W-1:0] symbol,
   input  logic [dbpm_pkg::CSR_W-1:0] open_symbols,
   input  logic [dbpm_pkg::CSR_W-1:0] close_symbols,
   input  logic [dbpm_pkg::TIU_W-1:0] types_in_use,
   output dbpm_pkg::dec_type          dec
);

   logic [NUM_TYPES-1:0] active;
   logic [NUM_TYPES-1:0] open_hit;
   logic [NUM_TYPES-1:0] close_hit;

   always_comb begin
      for (int t = 0; t < NUM_TYPES; t++) begin
         active[t] = (dbpm_pkg::TIU_W'(t) < types_in_use) &&
                     (open_symbols[8*t +: 8] != '0) && (close_symbols[8*t +: 8] != '0);
         open_hit[t]  = active[t] && (open_symbols[8*t +: 8] == symbol);
         close_hit[t] = active[t] && (close_symbols[8*t +: 8] == symbol);
      end
   end

   // lowest open match wins, then lowest close match
   always_comb begin
      dec.op  = dbpm_pkg::OP_NONE;
      dec.sel = '0;
      if (symbol == dbpm_pkg::DOT_CHAR) begin
         dec.op = dbpm_pkg::OP_DOT;
      end else if (open_hit != '0) begin
         dec.op = dbpm_pkg::OP_OPEN;
         for (int t = NUM_TYPES - 1; t >= 0; t--) begin
            if (open_hit[t]) begin
               dec.sel = dbpm_pkg::SEL_W'(t);
            end
         end
      end else if (close_hit != '0) begin
         dec.op = dbpm_pkg::OP_CLOSE;
         for (int t = NUM_TYPES - 1; t >= 0; t--) begin
            if (close_hit[t]) begin
               dec.sel = dbpm_pkg::SEL_W'(t);
            end
         end
      end
   end

endmodule

FILE: design/dbpm_stack.sv
// Per-type open-position stacks in one memory with a cached top of each stack.
module dbpm_stack #(
   parameter int NUM_TYPES   = 4,
   parameter int STACK_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dbpm_pkg::stk_cmd_type    cmd,
   output dbpm_pkg::stk_status_type status
);

   localparam int IDX_W     = $clog2(STACK_DEPTH);
   localparam int SP_W      = $clog2(STACK_DEPTH + 1);
   localparam int ROW_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int ADDR_W    = ROW_W + IDX_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   logic [dbpm_pkg::FIELD_W-1:0] mem [MEM_DEPTH];

   logic [SP_W-1:0]              sp_ff  [NUM_TYPES];
   logic [SP_W-1:0]              sp_in  [NUM_TYPES];
   logic [dbpm_pkg::FIELD_W-1:0] tos_ff [NUM_TYPES];
   logic                         rd_pend_ff;
   logic [ROW_W-1:0]             rd_row_ff;
   logic [dbpm_pkg::FIELD_W-1:0] rd_data_ff;

   logic [ROW_W-1:0]  row;
   logic [SP_W-1:0]   sp_sel;
   logic [SP_W-1:0]   sp_below;
   logic              do_push;
   logic              do_pop;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [NUM_TYPES-1:0] left;

   assign row      = cmd.sel[ROW_W-1:0];
   assign sp_sel   = sp_ff[row];
   assign sp_below = sp_sel - SP_W'(2);
   assign do_push  = cmd.exec && (cmd.op == dbpm_pkg::OP_OPEN) &&
                     (sp_sel != SP_W'(STACK_DEPTH));
   assign do_pop   = cmd.exec && (cmd.op == dbpm_pkg::OP_CLOSE) && (sp_sel != '0);
   // refill the cached top from the entry below the one being popped
   assign rd_en    = do_pop && (sp_sel >= SP_W'(2));
   assign wr_addr  = {row, sp_sel[IDX_W-1:0]};
   assign rd_addr  = {row, sp_below[IDX_W-1:0]};

   assign status.empty = (sp_sel == '0);
   assign status.full  = (sp_sel == SP_W'(STACK_DEPTH));
   // a refill that landed last cycle is newer than the cached copy
   assign status.top   = (rd_pend_ff && (rd_row_ff == row)) ? rd_data_ff : tos_ff[row];

   always_comb begin
      for (int t = 0; t < NUM_TYPES; t++) begin
         sp_in[t] = sp_ff[t];
         if (do_push && (row == ROW_W'(t))) begin
            sp_in[t] = sp_ff[t] + SP_W'(1);
         end else if (do_pop && (row == ROW_W'(t))) begin
            sp_in[t] = sp_ff[t] - SP_W'(1);
         end
         left[t] = (sp_in[t] != '0);
      end
   end

   assign status.any_left = |left;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_addr] <= cmd.position;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         rd_row_ff  <= '0;
      end else begin
         rd_pend_ff <= rd_en;
         rd_row_ff  <= row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TYPES; t++) begin
            sp_ff[t] <= '0;
         end
      end else if (cmd.exec) begin
         for (int t = 0; t < NUM_TYPES; t++) begin
            sp_ff[t] <= cmd.clear ? '0 : sp_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
         if (do_push && (row == ROW_W'(t))) begin
            tos_ff[t] <= cmd.position;
         end else if (rd_pend_ff && (rd_row_ff == ROW_W'(t))) begin
            tos_ff[t] <= rd_data_ff;
         end
      end
   end

endmodule

FILE: design/dbpm_rsp_queue.sv
// Two-slot result queue: up to two results per character, one per cycle out if ready.
module dbpm_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              w0_valid,
   input  dbpm_pkg::rsp_type w0,
   input  logic              w1_valid,
   input  dbpm_pkg::rsp_type w1,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dbpm_pkg::rsp_type rsp_data
);

   logic              s0_valid_ff;
   logic              s1_valid_ff;
   dbpm_pkg::rsp_type s0_ff;
   dbpm_pkg::rsp_type s1_ff;
   logic              drain;

   assign drain     = s0_valid_ff && rsp_ready;
   assign room      = !s1_valid_ff && (!s0_valid_ff || rsp_ready);
   assign rsp_valid = s0_valid_ff;
   assign rsp_data  = s0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s0_valid_ff <= w0_valid;
         s1_valid_ff <= w1_valid;
      end else if (drain) begin
         s0_valid_ff <= s1_valid_ff;
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s0_ff <= w0;
         s1_ff <= w1;
      end else if (drain) begin
         s0_ff <= s1_ff;
      end
   end

endmodule

FILE: design/dot_bracket_pair_matcher.sv
// Dot-bracket pair matcher: one structure character per cycle in, one result per cycle out
// while rsp_ready is high. A character is registered on acceptance and fully processed once
// the result queue has room: decode against the configured bracket bytes, one push or pop on
// its type's stack, and the dot, close and end-summary results written into a registered
// two-slot result queue, so a new character is taken every cycle while results drain. A
// character that gives both a dot or close result and the summary fills both queue slots,
// and the next character waits until the second slot drains. The stacks share one memory
// with one write and one registered read port; each type keeps its top of stack in a
// register so back-to-back pops need no stall. No clearing pass after reset: stack entries
// are only read below their stack pointer. Write configuration only while the block is idle.
module dot_bracket_pair_matcher #(
   parameter int MAX_LEN     = 1024,
   parameter int NUM_TYPES   = 4,
   parameter int STACK_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  dbpm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output dbpm_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [dbpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dbpm_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int LEN_LIMIT = (MAX_LEN < 1023) ? MAX_LEN : 1023;

   logic [dbpm_pkg::CSR_W-1:0] open_symbols_ff;
   logic [dbpm_pkg::CSR_W-1:0] close_symbols_ff;
   logic [dbpm_pkg::TIU_W-1:0] types_in_use_ff;

   logic                         a_valid_ff;
   dbpm_pkg::req_type            a_req_ff;
   logic [dbpm_pkg::POS_W-1:0]   pos_ff;
   logic [dbpm_pkg::POS_W-1:0]   pos_in;
   logic [dbpm_pkg::FIELD_W-1:0] pair_ff;
   logic [dbpm_pkg::FIELD_W-1:0] pair_in;
   logic [dbpm_pkg::CODE_W-1:0]  err_ff;
   logic [dbpm_pkg::CODE_W-1:0]  err_in;

   dbpm_pkg::dec_type        dec;
   dbpm_pkg::stk_cmd_type    stk_cmd;
   dbpm_pkg::stk_status_type stk_status;

   logic                         room;
   logic                         fire;
   logic                         over;
   logic [dbpm_pkg::POS_W-1:0]   pos_new;
   logic                         is_pair;
   logic                         has_res;
   logic [dbpm_pkg::CODE_W-1:0]  err_item;
   logic [dbpm_pkg::CODE_W-1:0]  sum_err;
   dbpm_pkg::rsp_type            res;
   dbpm_pkg::rsp_type            sum;
   dbpm_pkg::rsp_type            w0;
   logic                         w0_valid;
   logic                         w1_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         open_symbols_ff  <= dbpm_pkg::OPEN_SYMBOLS_RST;
         close_symbols_ff <= dbpm_pkg::CLOSE_SYMBOLS_RST;
         types_in_use_ff  <= dbpm_pkg::TYPES_IN_USE_RST;
      end else if (csr_we) begin
         case (csr_index)
            dbpm_pkg::CSR_OPEN_SYMBOLS:  open_symbols_ff  <= csr_wdata;
            dbpm_pkg::CSR_CLOSE_SYMBOLS: close_symbols_ff <= csr_wdata;
            dbpm_pkg::CSR_TYPES_IN_USE:  types_in_use_ff  <= csr_wdata[dbpm_pkg::TIU_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   assign fire      = a_valid_ff && room;
   assign req_ready = !a_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         a_valid_ff <= 1'b1;
      end else if (fire) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_req_ff <= req_data;
      end
   end

   dbpm_decode #(
      .NUM_TYPES (NUM_TYPES)
   ) u_decode (
      .symbol        (a_req_ff.symbol),
      .open_symbols  (open_symbols_ff),
      .close_symbols (close_symbols_ff),
      .types_in_use  (types_in_use_ff),
      .dec           (dec)
   );

   assign over    = (pos_ff >= dbpm_pkg::POS_W'(LEN_LIMIT));
   assign pos_new = pos_ff + dbpm_pkg::POS_W'(1);

   // characters past the length limit touch no stack
   assign stk_cmd.exec     = fire;
   assign stk_cmd.clear    = a_req_ff.last_symbol;
   assign stk_cmd.op       = over ? dbpm_pkg::OP_NONE : dec.op;
   assign stk_cmd.sel      = dec.sel;
   assign stk_cmd.position = pos_new[dbpm_pkg::FIELD_W-1:0];

   dbpm_stack #(
      .NUM_TYPES   (NUM_TYPES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stk_cmd),
      .status (stk_status)
   );

   always_comb begin
      err_item = dbpm_pkg::ERR_OK;
      if (over) begin
         err_item = dbpm_pkg::ERR_OVERFLOW;
      end else if ((dec.op == dbpm_pkg::OP_OPEN) && stk_status.full) begin
         err_item = dbpm_pkg::ERR_OVERFLOW;
      end else if ((dec.op == dbpm_pkg::OP_CLOSE) && stk_status.empty) begin
         err_item = dbpm_pkg::ERR_CLOSE_NO_OPEN;
      end
   end

   // keep the first error of the structure
   assign err_in  = (err_ff != dbpm_pkg::ERR_OK) ? err_ff : err_item;
   assign is_pair = !over && (dec.op == dbpm_pkg::OP_CLOSE) && !stk_status.empty;
   assign has_res = !over && ((dec.op == dbpm_pkg::OP_DOT) || (dec.op == dbpm_pkg::OP_CLOSE));
   assign pair_in = (is_pair && (pair_ff != dbpm_pkg::POS_FIELD_MAX)) ?
                    pair_ff + dbpm_pkg::FIELD_W'(1) : pair_ff;

   assign sum_err = (err_in != dbpm_pkg::ERR_OK) ? err_in :
                    (stk_status.any_left ? dbpm_pkg::ERR_OPENS_LEFT : dbpm_pkg::ERR_OK);

   always_comb begin
      res.position   = pos_new[dbpm_pkg::FIELD_W-1:0];
      res.partner    = is_pair ? stk_status.top : '0;
      res.kind       = is_pair ? dbpm_pkg::KIND_PAIR : dbpm_pkg::KIND_UNPAIRED;
      res.error_code = err_in;
      res.pair_count = pair_in;
      res.run_end    = 1'b0;

      sum.position   = '0;
      sum.partner    = '0;
      sum.kind       = dbpm_pkg::KIND_SUMMARY;
      sum.error_code = sum_err;
      sum.pair_count = pair_in;
      sum.run_end    = 1'b1;
   end

   // put the summary first when the character itself gives no result
   assign w0       = has_res ? res : sum;
   assign w0_valid = has_res || a_req_ff.last_symbol;
   assign w1_valid = has_res && a_req_ff.last_symbol;

   dbpm_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .w0_valid  (w0_valid),
      .w0        (w0),
      .w1_valid  (w1_valid),
      .w1        (sum),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always_comb begin
      pos_in = pos_new;
      if (a_req_ff.last_symbol) begin
         pos_in = '0;
      end else if (over) begin
         pos_in = dbpm_pkg::POS_W'(LEN_LIMIT + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pair_ff <= '0;
         err_ff  <= dbpm_pkg::ERR_OK;
      end else if (fire) begin
         pos_ff  <= pos_in;
         pair_ff <= a_req_ff.last_symbol ? '0 : pair_in;
         err_ff  <= a_req_ff.last_symbol ? dbpm_pkg::ERR_OK : err_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= dbpm_pkg::POS_W'(LEN_LIMIT + 1))
      else $error("position counter past its stop value");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      fire && a_req_ff.last_symbol |=> (pos_ff == '0) && (pair_ff == '0) &&
      (err_ff == dbpm_pkg::ERR_OK))
      else $error("structure state not cleared after last character");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != dbpm_pkg::ERR_OK) && !(fire && a_req_ff.last_symbol) |=>
      err_ff == $past(err_ff))
      else $error("recorded error changed within a structure");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == dbpm_pkg::KIND_PAIR) |->
      (rsp_data.partner != '0) && (rsp_data.partner < rsp_data.position))
      else $error("pair result with bad partner position");
`endif

endmodule
